/* rtl/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is low
`define UPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Same-cycle implication
`define UPA_IMPLY(label, ante, cons, msg) \
    `UPA_ASSERT(label, (ante) |-> (cons), msg)

`endif

/* rtl/upa_pkg.sv */
// Package: widths, opcodes, status codes, pipeline word types and shared helpers
package upa_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int FUNC_W    = 4;
    localparam int UNC_W     = WORD_BITS - 1;
    localparam int MAG_W     = WORD_BITS;
    localparam int PROD_W    = 2 * WORD_BITS - 1;
    localparam int NUM_W     = PROD_W + FRAC_BITS;
    localparam int DEN_W     = PROD_W;
    localparam int QUO_W     = WORD_BITS + 1;
    localparam int SQ_W      = 2 * WORD_BITS;
    localparam int ROOT_W    = WORD_BITS;
    localparam int REM_W     = WORD_BITS + 2;
    // front 3 + divider QUO_W + quadrature 2 + root ROOT_W + output 1
    localparam int LATENCY   = 6 + QUO_W + ROOT_W;

    localparam logic [MAG_W-1:0] HALF_M  = {1'b1, {(MAG_W-1){1'b0}}};
    localparam logic [MAG_W-1:0] UMAX_M  = {1'b0, {(MAG_W-1){1'b1}}};
    localparam logic [UNC_W-1:0] UNC_MAX = {UNC_W{1'b1}};

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZ    = 2'd1;
    localparam logic [1:0] ST_NEGROOT = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    typedef enum logic [FUNC_W-1:0] {
        F_COUNT = 4'd0,
        F_MAKE  = 4'd1,
        F_INV   = 4'd2,
        F_NEG   = 4'd3,
        F_ADD   = 4'd4,
        F_SUB   = 4'd5,
        F_MUL   = 4'd6,
        F_DIV   = 4'd7,
        F_SADD  = 4'd8,
        F_SSUB  = 4'd9,
        F_SMUL  = 4'd10,
        F_SDIV  = 4'd11,
        F_SMIN  = 4'd12,
        F_SOVER = 4'd13
    } t_func;

    // One division lane: partial remainder, divisor, dividend bits shifting
    // out at the top while quotient bits shift in at the bottom
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] nq;
        logic             ovf;
    } t_lane;

    // Side information travelling with a word through the divider chain
    typedef struct packed {
        t_func               func;
        logic                na;
        logic                dz;
        logic                dzneg;
        logic                qneg;
        logic [WORD_BITS-1:0] val;
        logic                val_sat;
        logic [MAG_W-1:0]    ua;
        logic [UNC_W-1:0]    ub;
        logic [MAG_W-1:0]    pm;
        logic [MAG_W-1:0]    qm;
        logic [MAG_W-1:0]    ma;
    } t_side;

    // Result word waiting on the root chain
    typedef struct packed {
        logic [WORD_BITS-1:0] val;
        logic [UNC_W-1:0]     unc;
        logic [1:0]           st;
        logic                 use_sqrt;
    } t_fin;

    // Signed saturation of a magnitude; returns {saturated, value}
    function automatic logic [WORD_BITS:0] sat_val(input logic [QUO_W-1:0] m,
                                                   input logic neg);
        logic [QUO_W-1:0]     lim;
        logic [WORD_BITS-1:0] mm;
        logic                 sat;
        lim = neg ? QUO_W'(HALF_M) : QUO_W'(UMAX_M);
        sat = (m > lim);
        mm  = sat ? lim[WORD_BITS-1:0] : m[WORD_BITS-1:0];
        return {sat, (neg ? (~mm + 1'b1) : mm)};
    endfunction

endpackage

/* rtl/upa_front.sv */
// Front end: operand magnitudes, products, value path and divider lane set-up
module upa_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [upa_pkg::FUNC_W-1:0]     i_func,
    input  logic signed [upa_pkg::WORD_BITS-1:0] i_a_value,
    input  logic signed [upa_pkg::WORD_BITS-1:0] i_a_unc,
    input  logic signed [upa_pkg::WORD_BITS-1:0] i_b_value,
    input  logic [upa_pkg::UNC_W-1:0]      i_b_unc,
    output logic                           o_valid,
    output upa_pkg::t_side                 o_side,
    output upa_pkg::t_lane                 o_lane_v,
    output upa_pkg::t_lane                 o_lane_p,
    output upa_pkg::t_lane                 o_lane_q
);
    import upa_pkg::*;

    localparam int SH_W = PROD_W - FRAC_BITS;

    function automatic logic [MAG_W-1:0] mag(input logic [WORD_BITS-1:0] v);
        return v[WORD_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic t_lane make_lane(input logic [NUM_W-1:0] n,
                                        input logic [DEN_W-1:0] d);
        t_lane            l;
        logic [NUM_W-1:0] top;
        top   = n >> QUO_W;
        l.ovf = (top >= NUM_W'(d));
        l.rem = top[DEN_W-1:0];
        l.nq  = n[QUO_W-1:0];
        l.den = d;
        return l;
    endfunction

    // stage 1: register operands and magnitudes
    logic                        r_s1_valid;
    t_func                       r_s1_func;
    logic signed [WORD_BITS-1:0] r_s1_a, r_s1_b;
    logic [MAG_W-1:0]            r_s1_ma, r_s1_mb, r_s1_ua;
    logic [UNC_W-1:0]            r_s1_ub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_start;
        end
        r_s1_func <= t_func'(i_func);
        r_s1_a    <= i_a_value;
        r_s1_b    <= i_b_value;
        r_s1_ma   <= mag(i_a_value);
        r_s1_mb   <= mag(i_b_value);
        r_s1_ua   <= mag(i_a_unc);
        r_s1_ub   <= i_b_unc;
    end

    // stage 2: the five products and the sum or difference
    logic signed [WORD_BITS:0] n_s;
    logic [SQ_W-1:0]           n_ab, n_ub, n_vb, n_aa, n_bb;

    always_comb begin
        n_ab = SQ_W'(r_s1_ma) * SQ_W'(r_s1_mb);
        n_ub = SQ_W'(r_s1_ua) * SQ_W'(r_s1_mb);
        n_vb = SQ_W'(r_s1_ub) * SQ_W'(r_s1_ma);
        n_aa = SQ_W'(r_s1_ma) * SQ_W'(r_s1_ma);
        n_bb = SQ_W'(r_s1_mb) * SQ_W'(r_s1_mb);
        case (r_s1_func) inside
            F_ADD, F_SADD: n_s = (WORD_BITS+1)'(r_s1_a) + (WORD_BITS+1)'(r_s1_b);
            F_SUB, F_SSUB: n_s = (WORD_BITS+1)'(r_s1_a) - (WORD_BITS+1)'(r_s1_b);
            F_SMIN:        n_s = (WORD_BITS+1)'(r_s1_b) - (WORD_BITS+1)'(r_s1_a);
            default:       n_s = '0;
        endcase
    end

    logic                        r_s2_valid;
    t_func                       r_s2_func;
    logic signed [WORD_BITS-1:0] r_s2_a;
    logic signed [WORD_BITS:0]   r_s2_s;
    logic                        r_s2_na, r_s2_nb;
    logic [MAG_W-1:0]            r_s2_ma, r_s2_mb, r_s2_ua;
    logic [UNC_W-1:0]            r_s2_ub;
    logic [PROD_W-1:0]           r_s2_ab, r_s2_ub_mb, r_s2_vb, r_s2_aa, r_s2_bb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_func  <= r_s1_func;
        r_s2_a     <= r_s1_a;
        r_s2_s     <= n_s;
        r_s2_na    <= r_s1_a[WORD_BITS-1];
        r_s2_nb    <= r_s1_b[WORD_BITS-1];
        r_s2_ma    <= r_s1_ma;
        r_s2_mb    <= r_s1_mb;
        r_s2_ua    <= r_s1_ua;
        r_s2_ub    <= r_s1_ub;
        r_s2_ab    <= n_ab[PROD_W-1:0];
        r_s2_ub_mb <= n_ub[PROD_W-1:0];
        r_s2_vb    <= n_vb[PROD_W-1:0];
        r_s2_aa    <= n_aa[PROD_W-1:0];
        r_s2_bb    <= n_bb[PROD_W-1:0];
    end

    // stage 3: value for the non-dividing ops, clamped product errors, lanes
    logic [SH_W-1:0]      n_ab_f, n_ub_f, n_vb_f;
    logic [QUO_W-1:0]     n_mq, n_abs_s;
    logic [WORD_BITS:0]   n_sv;
    logic [NUM_W-1:0]     n_nv, n_np, n_nqq;
    logic [DEN_W-1:0]     n_dv, n_dp, n_dq;
    t_side                n_side;

    always_comb begin
        n_ab_f  = r_s2_ab[PROD_W-1:FRAC_BITS];
        n_ub_f  = r_s2_ub_mb[PROD_W-1:FRAC_BITS];
        n_vb_f  = r_s2_vb[PROD_W-1:FRAC_BITS];
        n_mq    = (n_ab_f > SH_W'({QUO_W{1'b1}})) ? {QUO_W{1'b1}} : n_ab_f[QUO_W-1:0];
        n_abs_s = r_s2_s[WORD_BITS] ? QUO_W'(~r_s2_s + 1'b1) : QUO_W'(r_s2_s);

        case (r_s2_func) inside
            F_COUNT, F_MAKE:                  n_sv = {1'b0, r_s2_a};
            F_NEG:                            n_sv = sat_val(QUO_W'(r_s2_ma), !r_s2_na);
            F_ADD, F_SUB, F_SADD, F_SSUB,
            F_SMIN:                           n_sv = sat_val(n_abs_s, r_s2_s[WORD_BITS]);
            F_MUL, F_SMUL:                    n_sv = sat_val(n_mq, r_s2_na ^ r_s2_nb);
            default:                          n_sv = '0;
        endcase

        n_side.func    = r_s2_func;
        n_side.na      = r_s2_na;
        n_side.qneg    = (r_s2_func == F_INV) ? r_s2_na : (r_s2_na ^ r_s2_nb);
        n_side.val     = n_sv[WORD_BITS-1:0];
        n_side.val_sat = n_sv[WORD_BITS];
        n_side.ua      = r_s2_ua;
        n_side.ub      = r_s2_ub;
        n_side.pm      = (n_ub_f > SH_W'(HALF_M)) ? HALF_M : n_ub_f[MAG_W-1:0];
        n_side.qm      = (n_vb_f > SH_W'(HALF_M)) ? HALF_M : n_vb_f[MAG_W-1:0];
        n_side.ma      = r_s2_ma;

        // dividend and divisor per lane
        n_nv  = '0;
        n_dv  = '0;
        n_np  = '0;
        n_dp  = '0;
        n_nqq = '0;
        n_dq  = '0;
        n_side.dz    = 1'b0;
        n_side.dzneg = 1'b0;
        case (r_s2_func) inside
            F_INV: begin
                n_nv  = NUM_W'(1) << (2 * FRAC_BITS);
                n_dv  = DEN_W'(r_s2_ma);
                n_nqq = NUM_W'(r_s2_ua) << (2 * FRAC_BITS);
                n_dq  = r_s2_aa;
                n_side.dz = (r_s2_ma == '0);
            end
            F_DIV, F_SDIV: begin
                n_nv  = NUM_W'(r_s2_ma) << FRAC_BITS;
                n_dv  = DEN_W'(r_s2_mb);
                n_np  = NUM_W'(r_s2_ua) << FRAC_BITS;
                n_dp  = DEN_W'(r_s2_mb);
                n_nqq = NUM_W'(r_s2_vb) << FRAC_BITS;
                n_dq  = r_s2_bb;
                n_side.dz    = (r_s2_mb == '0);
                n_side.dzneg = r_s2_na;
            end
            F_SOVER: begin
                n_nv  = NUM_W'(r_s2_mb) << FRAC_BITS;
                n_dv  = DEN_W'(r_s2_ma);
                n_nqq = NUM_W'(r_s2_ub_mb) << FRAC_BITS;
                n_dq  = r_s2_aa;
                n_side.dz    = (r_s2_ma == '0);
                n_side.dzneg = r_s2_nb;
            end
            default: begin
                n_side.dz = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_s2_valid;
        end
        o_side   <= n_side;
        o_lane_v <= make_lane(n_nv, n_dv);
        o_lane_p <= make_lane(n_np, n_dp);
        o_lane_q <= make_lane(n_nqq, n_dq);
    end

endmodule

/* rtl/upa_div_cell.sv */
// Divider cell: one restoring quotient bit on each of the three lanes
module upa_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  upa_pkg::t_side i_side,
    input  upa_pkg::t_lane i_lane_v,
    input  upa_pkg::t_lane i_lane_p,
    input  upa_pkg::t_lane i_lane_q,
    output logic           o_valid,
    output upa_pkg::t_side o_side,
    output upa_pkg::t_lane o_lane_v,
    output upa_pkg::t_lane o_lane_p,
    output upa_pkg::t_lane o_lane_q
);
    import upa_pkg::*;

    // shift one dividend bit into the remainder, subtract where it fits
    function automatic t_lane step(input t_lane l);
        t_lane            r;
        logic [DEN_W:0]   sh;
        logic             fit;
        sh    = {l.rem, l.nq[QUO_W-1]};
        fit   = (sh >= {1'b0, l.den});
        r.rem = fit ? DEN_W'(sh - {1'b0, l.den}) : sh[DEN_W-1:0];
        r.nq  = {l.nq[QUO_W-2:0], fit};
        r.den = l.den;
        r.ovf = l.ovf;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_side   <= i_side;
        o_lane_v <= step(i_lane_v);
        o_lane_p <= step(i_lane_p);
        o_lane_q <= step(i_lane_q);
    end

endmodule

/* rtl/upa_quad.sv */
// Quadrature stage: quotient clamping, error squares and sum, result word set-up
module upa_quad (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  upa_pkg::t_side           i_side,
    input  upa_pkg::t_lane           i_lane_v,
    input  upa_pkg::t_lane           i_lane_p,
    input  upa_pkg::t_lane           i_lane_q,
    output logic                     o_valid,
    output logic [upa_pkg::SQ_W-1:0] o_x,
    output upa_pkg::t_fin            o_fin
);
    import upa_pkg::*;

    function automatic logic [QUO_W-1:0] lane_res(input t_lane l);
        return l.ovf ? {QUO_W{1'b1}} : l.nq;
    endfunction

    function automatic logic [MAG_W-1:0] clamp_half(input logic [QUO_W-1:0] m);
        return (m > QUO_W'(HALF_M)) ? HALF_M : m[MAG_W-1:0];
    endfunction

    function automatic logic unc_over(input logic [QUO_W-1:0] m);
        return (m > QUO_W'(UNC_MAX));
    endfunction

    function automatic logic [UNC_W-1:0] sat_unc(input logic [QUO_W-1:0] m);
        return unc_over(m) ? UNC_MAX : m[UNC_W-1:0];
    endfunction

    logic [QUO_W-1:0]   n_lv, n_lp, n_lq, n_um;
    logic [MAG_W-1:0]   n_p, n_q;
    logic [WORD_BITS:0] n_sv;
    logic               n_sat;
    t_fin               n_fin;

    // error terms for quadrature and the word for the other ops
    always_comb begin
        n_lv  = lane_res(i_lane_v);
        n_lp  = lane_res(i_lane_p);
        n_lq  = lane_res(i_lane_q);
        n_um  = '0;
        n_sv  = {i_side.val_sat, i_side.val};
        n_sat = 1'b0;
        n_p   = '0;
        n_q   = '0;
        n_fin.use_sqrt = 1'b0;
        case (i_side.func) inside
            F_ADD, F_SUB: begin
                n_p = i_side.ua;
                n_q = MAG_W'(i_side.ub);
                n_fin.use_sqrt = 1'b1;
            end
            F_MUL: begin
                n_p = i_side.pm;
                n_q = i_side.qm;
                n_fin.use_sqrt = 1'b1;
            end
            F_DIV: begin
                n_p  = clamp_half(n_lp);
                n_q  = clamp_half(n_lq);
                n_sv = sat_val(n_lv, i_side.qneg);
                n_fin.use_sqrt = 1'b1;
            end
            F_COUNT: begin
                n_fin.use_sqrt = !i_side.na;
            end
            F_MAKE, F_NEG, F_SADD, F_SSUB, F_SMIN: begin
                n_um  = QUO_W'(i_side.ua);
                n_sat = unc_over(n_um);
            end
            F_INV, F_SOVER: begin
                n_um  = n_lq;
                n_sat = unc_over(n_um);
                n_sv  = sat_val(n_lv, i_side.qneg);
            end
            F_SDIV: begin
                n_um  = n_lp;
                n_sat = unc_over(n_um);
                n_sv  = sat_val(n_lv, i_side.qneg);
            end
            F_SMUL: begin
                n_um  = QUO_W'(i_side.pm);
                n_sat = unc_over(n_um);
            end
            default: begin
                n_sv = '0;
            end
        endcase

        n_fin.val = n_sv[WORD_BITS-1:0];
        n_fin.unc = sat_unc(n_um);
        if (i_side.dz) begin
            n_fin.val      = i_side.dzneg ? HALF_M : UMAX_M;
            n_fin.unc      = UNC_MAX;
            n_fin.st       = ST_DIVZ;
            n_fin.use_sqrt = 1'b0;
        end else if (i_side.func == F_COUNT && i_side.na) begin
            n_fin.st = ST_NEGROOT;
        end else if (n_sv[WORD_BITS] || n_sat) begin
            n_fin.st = ST_SAT;
        end else begin
            n_fin.st = ST_OK;
        end
    end

    // stage a: squares of the two error terms
    logic            r_a_valid;
    t_fin            r_a_fin;
    logic            r_a_cnt;
    logic [SQ_W-1:0] r_a_sqp, r_a_sqq, r_a_cx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_fin <= n_fin;
        r_a_cnt <= (i_side.func == F_COUNT);
        r_a_sqp <= SQ_W'(n_p) * SQ_W'(n_p);
        r_a_sqq <= SQ_W'(n_q) * SQ_W'(n_q);
        r_a_cx  <= SQ_W'(i_side.ma) << FRAC_BITS;
    end

    // stage b: radicand for the root chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_a_valid;
        end
        o_fin <= r_a_fin;
        o_x   <= r_a_cnt ? r_a_cx : (r_a_sqp + r_a_sqq);
    end

endmodule

/* rtl/upa_sqrt_cell.sv */
// Root cell: one digit-by-digit square root bit per stage
module upa_sqrt_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [upa_pkg::SQ_W-1:0]   i_x,
    input  logic [upa_pkg::REM_W-1:0]  i_rem,
    input  logic [upa_pkg::ROOT_W-1:0] i_root,
    input  upa_pkg::t_fin              i_fin,
    output logic                       o_valid,
    output logic [upa_pkg::SQ_W-1:0]   o_x,
    output logic [upa_pkg::REM_W-1:0]  o_rem,
    output logic [upa_pkg::ROOT_W-1:0] o_root,
    output upa_pkg::t_fin              o_fin
);
    import upa_pkg::*;

    logic [REM_W+1:0] n_sh, n_trial;
    logic             n_fit;

    // bring down two radicand bits, try root*4+1
    always_comb begin
        n_sh    = {i_rem, i_x[SQ_W-1:SQ_W-2]};
        n_trial = (REM_W+2)'({i_root, 2'b01});
        n_fit   = (n_sh >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_fin  <= i_fin;
        o_x    <= i_x << 2;
        o_rem  <= n_fit ? REM_W'(n_sh - n_trial) : n_sh[REM_W-1:0];
        o_root <= {i_root[ROOT_W-2:0], n_fit};
    end

endmodule

/* rtl/uncertainty_propagation_alu.sv */
// Top level: uncertainty propagation ALU, front end, divider chain, root chain
//
//  Channel  | Direction | Handshake       | Word
//  ---------+-----------+-----------------+----------------------------------------
//  command  | in        | start, busy     | i_func, i_a_value, i_a_unc, i_b_value, i_b_unc
//  result   | out       | o_valid strobe  | o_out_value, o_out_unc, o_status
//
//  One word accepted every cycle; busy stays low, the pipeline never stalls.
//  Each result passes through the front end, the 33-cell restoring divider
//  chain, the quadrature stage, the 32-cell square-root chain and the output register.
//  o_valid is high for one cycle per word; the receiver cannot hold it off.
//  Synchronous active-low reset clears the valid bits only.
module uncertainty_propagation_alu (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [upa_pkg::FUNC_W-1:0]           i_func,
    input  logic signed [upa_pkg::WORD_BITS-1:0] i_a_value,
    input  logic signed [upa_pkg::WORD_BITS-1:0] i_a_unc,
    input  logic signed [upa_pkg::WORD_BITS-1:0] i_b_value,
    input  logic [upa_pkg::UNC_W-1:0]            i_b_unc,
    output logic                                 o_valid,
    output logic signed [upa_pkg::WORD_BITS-1:0] o_out_value,
    output logic [upa_pkg::UNC_W-1:0]            o_out_unc,
    output logic [1:0]                           o_status
);
    import upa_pkg::*;

    assign busy = 1'b0;

    // divider chain
    logic  dv   [0:QUO_W];
    t_side ds   [0:QUO_W];
    t_lane dl_v [0:QUO_W];
    t_lane dl_p [0:QUO_W];
    t_lane dl_q [0:QUO_W];

    upa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_func    (i_func),
        .i_a_value (i_a_value),
        .i_a_unc   (i_a_unc),
        .i_b_value (i_b_value),
        .i_b_unc   (i_b_unc),
        .o_valid   (dv[0]),
        .o_side    (ds[0]),
        .o_lane_v  (dl_v[0]),
        .o_lane_p  (dl_p[0]),
        .o_lane_q  (dl_q[0])
    );

    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        upa_div_cell u_div (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (dv[g]),
            .i_side   (ds[g]),
            .i_lane_v (dl_v[g]),
            .i_lane_p (dl_p[g]),
            .i_lane_q (dl_q[g]),
            .o_valid  (dv[g+1]),
            .o_side   (ds[g+1]),
            .o_lane_v (dl_v[g+1]),
            .o_lane_p (dl_p[g+1]),
            .o_lane_q (dl_q[g+1])
        );
    end

    // root chain
    logic              sv    [0:ROOT_W];
    logic [SQ_W-1:0]   sx    [0:ROOT_W];
    logic [REM_W-1:0]  srem  [0:ROOT_W];
    logic [ROOT_W-1:0] sroot [0:ROOT_W];
    t_fin              sf    [0:ROOT_W];

    assign srem[0]  = '0;
    assign sroot[0] = '0;

    upa_quad u_quad (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (dv[QUO_W]),
        .i_side   (ds[QUO_W]),
        .i_lane_v (dl_v[QUO_W]),
        .i_lane_p (dl_p[QUO_W]),
        .i_lane_q (dl_q[QUO_W]),
        .o_valid  (sv[0]),
        .o_x      (sx[0]),
        .o_fin    (sf[0])
    );

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        upa_sqrt_cell u_sqrt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sv[g]),
            .i_x     (sx[g]),
            .i_rem   (srem[g]),
            .i_root  (sroot[g]),
            .i_fin   (sf[g]),
            .o_valid (sv[g+1]),
            .o_x     (sx[g+1]),
            .o_rem   (srem[g+1]),
            .o_root  (sroot[g+1]),
            .o_fin   (sf[g+1])
        );
    end

    // output register: merge the root into the result word
    logic                 r_valid;
    logic [WORD_BITS-1:0] r_value;
    logic [UNC_W-1:0]     r_unc;
    logic [1:0]           r_status;
    logic                 n_over;

    assign n_over = sf[ROOT_W].use_sqrt && sroot[ROOT_W][ROOT_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= sv[ROOT_W];
        end
        r_value <= sf[ROOT_W].val;
        if (sf[ROOT_W].use_sqrt) begin
            r_unc <= n_over ? UNC_MAX : sroot[ROOT_W][UNC_W-1:0];
        end else begin
            r_unc <= sf[ROOT_W].unc;
        end
        r_status <= n_over ? ST_SAT : sf[ROOT_W].st;
    end

    assign o_valid     = r_valid;
    assign o_out_value = r_value;
    assign o_out_unc   = r_unc;
    assign o_status    = r_status;

endmodule

/* rtl/upa_checker.sv */
// Port-level checker for the uncertainty propagation ALU, bound to the top level
`include "assert_macros.svh"

module upa_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 o_valid,
    input logic signed [upa_pkg::WORD_BITS-1:0] o_out_value,
    input logic [upa_pkg::UNC_W-1:0]            o_out_unc,
    input logic [1:0]                           o_status
);
    import upa_pkg::*;

    logic divz_end;
    logic divz_hit;

    // end-of-range value expected on a divide by zero
    assign divz_end = (o_out_value == UMAX_M) || (o_out_value == HALF_M);
    assign divz_hit = o_valid && (o_status == ST_DIVZ);

    // every result word traces back to a start a fixed time earlier
    `UPA_IMPLY(a_latency, o_valid, $past(start, LATENCY), "result word without a start")

    // divide by zero gives full uncertainty and an end-of-range value
    `UPA_IMPLY(a_divz_word, divz_hit, (o_out_unc == UNC_MAX) && divz_end, "bad divide-by-zero word")

    // negative root keeps the negative value and reports no uncertainty
    `UPA_IMPLY(a_negroot_word, o_valid && o_status == ST_NEGROOT, (o_out_unc == '0) && o_out_value[WORD_BITS-1], "bad negative-root word")

    // the pipeline never pushes back
    `UPA_ASSERT(a_never_busy, !busy, "busy raised")

endmodule

bind uncertainty_propagation_alu upa_checker u_upa_checker (.*);

/* tb/sv/uncertainty_propagation_alu_tb.sv */
// Testbench for the uncertainty propagation ALU: directed and random words against a predictor
`timescale 1ns / 100ps

module uncertainty_propagation_alu_tb;
    import upa_pkg::*;

    typedef bit [127:0] t_wide;

    typedef struct {
        bit signed [WORD_BITS-1:0] val;
        bit [UNC_W-1:0]            unc;
        bit [1:0]                  st;
    } t_result;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [FUNC_W-1:0]           i_func;
    logic signed [WORD_BITS-1:0] i_a_value;
    logic signed [WORD_BITS-1:0] i_a_unc;
    logic signed [WORD_BITS-1:0] i_b_value;
    logic [UNC_W-1:0]            i_b_unc;
    logic                        o_valid;
    logic signed [WORD_BITS-1:0] o_out_value;
    logic [UNC_W-1:0]            o_out_unc;
    logic [1:0]                  o_status;

    t_result expected_q[$];
    int      mismatches;
    bit      gaps_on;

    localparam bit signed [WORD_BITS-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam bit signed [WORD_BITS-1:0] VMIN = 32'sh8000_0000;
    localparam bit signed [WORD_BITS-1:0] ONE  = 32'sh0001_0000;

    uncertainty_propagation_alu dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_func     (i_func),
        .i_a_value  (i_a_value),
        .i_a_unc    (i_a_unc),
        .i_b_value  (i_b_value),
        .i_b_unc    (i_b_unc),
        .o_valid    (o_valid),
        .o_out_value(o_out_value),
        .o_out_unc  (o_out_unc),
        .o_status   (o_status)
    );

    // Clock, 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Floor of the square root, bit by bit
    function automatic t_wide root_floor(input t_wide x);
        t_wide res;
        t_wide b;
        res = '0;
        b = t_wide'(1) << 126;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Clamp a magnitude to the signed range and apply the sign
    function automatic bit [WORD_BITS-1:0] clamp_value(input t_wide m, input bit neg,
                                                       inout bit sat);
        t_wide lim;
        lim = neg ? (t_wide'(1) << 31) : ((t_wide'(1) << 31) - 1);
        if (m > lim) begin
            sat = 1'b1;
            m = lim;
        end
        return neg ? -m[WORD_BITS-1:0] : m[WORD_BITS-1:0];
    endfunction

    function automatic bit [UNC_W-1:0] clamp_unc(input t_wide m, inout bit sat);
        if (m > ((t_wide'(1) << 31) - 1)) begin
            sat = 1'b1;
            return '1;
        end
        return m[UNC_W-1:0];
    endfunction

    function automatic t_wide limit_half(input t_wide m);
        return (m > (t_wide'(1) << 31)) ? (t_wide'(1) << 31) : m;
    endfunction

    function automatic bit [UNC_W-1:0] quadrature(input t_wide p, input t_wide q,
                                                  inout bit sat);
        return clamp_unc(root_floor(p * p + q * q), sat);
    endfunction

    function automatic t_wide abs_wide(input longint v);
        return (v < 0) ? t_wide'(-v) : t_wide'(v);
    endfunction

    // Value, uncertainty and status of one command word
    function automatic t_result propagate(input bit [3:0] f, input bit signed [31:0] av,
                                          input bit signed [31:0] au,
                                          input bit signed [31:0] bv, input bit [30:0] bu);
        t_result r;
        longint  a, b, s;
        t_wide   ma, mb, ua, ub, p, q;
        bit      na, nb, sat, dz, dzneg;
        a = av; b = bv;
        ma = abs_wide(a); mb = abs_wide(b);
        ua = abs_wide(longint'(au)); ub = t_wide'(bu);
        na = a < 0; nb = b < 0;
        sat = 0; dz = 0; dzneg = 0;
        r.val = '0; r.unc = '0; r.st = ST_OK;
        case (f)
            F_COUNT: begin
                r.val = av;
                if (na) r.st = ST_NEGROOT;
                else r.unc = clamp_unc(root_floor(ma << FRAC_BITS), sat);
            end
            F_MAKE: begin
                r.val = av;
                r.unc = clamp_unc(ua, sat);
            end
            F_INV: begin
                if (a == 0) dz = 1;
                else begin
                    r.val = clamp_value((t_wide'(1) << (2 * FRAC_BITS)) / ma, na, sat);
                    r.unc = clamp_unc((ua << (2 * FRAC_BITS)) / (ma * ma), sat);
                end
            end
            F_NEG: begin
                r.val = clamp_value(ma, !na, sat);
                r.unc = clamp_unc(ua, sat);
            end
            F_ADD, F_SUB: begin
                s = (f == F_ADD) ? a + b : a - b;
                r.val = clamp_value(abs_wide(s), s < 0, sat);
                r.unc = quadrature(ua, ub, sat);
            end
            F_MUL: begin
                r.val = clamp_value((ma * mb) >> FRAC_BITS, na != nb, sat);
                p = limit_half((ua * mb) >> FRAC_BITS);
                q = limit_half((ub * ma) >> FRAC_BITS);
                r.unc = quadrature(p, q, sat);
            end
            F_DIV: begin
                if (b == 0) begin
                    dz = 1; dzneg = na;
                end else begin
                    r.val = clamp_value((ma << FRAC_BITS) / mb, na != nb, sat);
                    p = limit_half((ua << FRAC_BITS) / mb);
                    q = limit_half(((ub * ma) << FRAC_BITS) / (mb * mb));
                    r.unc = quadrature(p, q, sat);
                end
            end
            F_SADD, F_SSUB, F_SMIN: begin
                s = (f == F_SADD) ? a + b : (f == F_SSUB) ? a - b : b - a;
                r.val = clamp_value(abs_wide(s), s < 0, sat);
                r.unc = clamp_unc(ua, sat);
            end
            F_SMUL: begin
                r.val = clamp_value((ma * mb) >> FRAC_BITS, na != nb, sat);
                r.unc = clamp_unc((ua * mb) >> FRAC_BITS, sat);
            end
            F_SDIV: begin
                if (b == 0) begin
                    dz = 1; dzneg = na;
                end else begin
                    r.val = clamp_value((ma << FRAC_BITS) / mb, na != nb, sat);
                    r.unc = clamp_unc((ua << FRAC_BITS) / mb, sat);
                end
            end
            F_SOVER: begin
                if (a == 0) begin
                    dz = 1; dzneg = nb;
                end else begin
                    r.val = clamp_value((mb << FRAC_BITS) / ma, na != nb, sat);
                    r.unc = clamp_unc(((ua * mb) << FRAC_BITS) / (ma * ma), sat);
                end
            end
            default: ;
        endcase
        if (dz) begin
            r.val = dzneg ? VMIN : VMAX;
            r.unc = '1;
            r.st = ST_DIVZ;
        end else if (r.st == ST_OK && sat) begin
            r.st = ST_SAT;
        end
        return r;
    endfunction

    // Send one command word and log its expected result on acceptance
    task automatic send_word(input bit [3:0] f, input bit signed [31:0] av,
                             input bit signed [31:0] au, input bit signed [31:0] bv,
                             input bit [30:0] bu);
        int gap;
        start     <= 1'b1;
        i_func    <= f;
        i_a_value <= av;
        i_a_unc   <= au;
        i_b_value <= bv;
        i_b_unc   <= bu;
        do @(posedge i_clk); while (busy);
        expected_q.push_back(propagate(f, av, au, bv, bu));
        if (gaps_on && $urandom_range(0, 99) < 14) begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    // Operand values: extremes, values near one, moderate and full range
    function automatic bit [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: case ($urandom_range(0, 4))
                   0: return 32'h0;
                   1: return 32'h1;
                   2: return 32'hFFFF_FFFF;
                   3: return VMAX;
                   default: return VMIN;
               endcase
            2, 3: return $urandom_range(0, 4 * 65536) * ($urandom_range(0, 1) ? 1 : -1);
            default: return $urandom_range(0, 1 << 24) * ($urandom_range(0, 1) ? 1 : -1);
        endcase
    endfunction

    task automatic send_random;
        bit [3:0] f;
        f = ($urandom_range(0, 49) == 0) ? 4'($urandom_range(14, 15))
                                         : 4'($urandom_range(0, 13));
        send_word(f, pick_operand(), pick_operand(), pick_operand(),
                  ($urandom_range(0, 3) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 1 << 20)));
    endtask

    // Extremes, every operation and the special cases
    task automatic test_directed;
        send_word(F_COUNT, 32'sh0, 32'sh0, 32'sh0, 31'h0);
        send_word(F_COUNT, -ONE, 32'sh0, 32'sh0, 31'h0);
        send_word(F_COUNT, VMAX, 32'sh0, 32'sh0, 31'h0);
        send_word(F_MAKE, ONE, VMIN, 32'sh0, 31'h0);
        send_word(F_MAKE, VMIN, -ONE, 32'sh0, 31'h0);
        send_word(F_INV, 32'sh0, ONE, 32'sh0, 31'h0);
        send_word(F_INV, 32'sh1, ONE, 32'sh0, 31'h0);
        send_word(F_INV, -(2 * ONE), VMIN, 32'sh0, 31'h0);
        send_word(F_NEG, VMIN, 32'sh5, 32'sh0, 31'h0);
        send_word(F_ADD, VMAX, VMAX, ONE, '1);
        send_word(F_SUB, VMIN, VMIN, ONE, '1);
        send_word(F_MUL, 32'sh0, ONE, 32'sh0, 31'h1_0000);
        send_word(F_MUL, VMAX, VMIN, VMIN, '1);
        send_word(F_DIV, -ONE, ONE, 32'sh0, 31'h1);
        send_word(F_DIV, 3 * ONE, ONE / 4, 32'sh1, '1);
        send_word(F_SADD, VMAX, ONE, ONE, '1);
        send_word(F_SSUB, VMIN, VMIN, ONE, 31'h0);
        send_word(F_SMUL, -(3 * ONE), VMIN, VMIN, 31'h0);
        send_word(F_SDIV, -ONE, ONE, 32'sh0, 31'h0);
        send_word(F_SDIV, 7 * ONE, ONE, -(2 * ONE), 31'h0);
        send_word(F_SMIN, VMAX, ONE, VMIN, 31'h0);
        send_word(F_SOVER, 32'sh0, ONE, -ONE, 31'h0);
        send_word(F_SOVER, 32'sh1, VMIN, VMAX, 31'h0);
        send_word(4'd14, ONE, ONE, ONE, '1);
        send_word(4'd15, VMIN, VMIN, VMIN, '1);
    endtask

    task automatic test_random_idle;
        repeat (1200) send_random();
    endtask

    // Back to back words, no gaps
    task automatic test_burst;
        gaps_on = 0;
        repeat (400) send_random();
        gaps_on = 1;
    endtask

    // Sender holds off until the pipe is empty, then resumes
    task automatic test_pause_drain;
        repeat (100) send_random();
        start <= 1'b0;
        drain();
        @(posedge i_clk);
        repeat (125) send_random();
    endtask

    // Compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: val %h unc %h st %0d",
                             o_out_value, o_out_unc, o_status);
            end else begin
                e = expected_q.pop_front();
                if (o_out_value !== e.val || o_out_unc !== e.unc || o_status !== e.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp val %h unc %h st %0d, got val %h unc %h st %0d",
                                 e.val, e.unc, e.st, o_out_value, o_out_unc, o_status);
                end
            end
        end
    end

    // Watchdog
    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_func = '0;
        i_a_value = '0;
        i_a_unc = '0;
        i_b_value = '0;
        i_b_unc = '0;
        mismatches = 0;
        gaps_on = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_idle();
        test_burst();
        test_pause_drain();
        start <= 1'b0;
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/upa_pkg.sv
rtl/upa_front.sv
rtl/upa_div_cell.sv
rtl/upa_quad.sv
rtl/upa_sqrt_cell.sv
rtl/uncertainty_propagation_alu.sv
rtl/upa_checker.sv
tb/sv/uncertainty_propagation_alu_tb.sv
